### src/grld_pkg.sv
package grld_pkg;

    // Default limit on collected group bytes
    localparam int GROUP_MAX_DEF = 7;

    // Group store depth and field widths
    localparam int STORE_DEPTH = 7;
    localparam int LEN_W       = 3;
    localparam int CNT_W       = 4;

    // Words held between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // Character codes
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] CLOSE_MARK = 8'h2C;   // ','
    localparam logic [7:0] DIGIT_LO   = 8'h32;   // '2'
    localparam logic [7:0] DIGIT_HI   = 8'h39;   // '9'

    typedef logic [7:0] t_byte;

    // One replay command: a pass-through byte is a group of one, repeated once
    typedef struct packed {
        t_byte [STORE_DEPTH-1:0] bytes;
        logic [LEN_W-1:0]        len;
        logic [CNT_W-1:0]        cnt;
        logic                    ovf;
    } t_grp_cmd;

    // Map the shifted digit symbols back to digits
    function automatic t_byte substitute(input t_byte b);
        t_byte r;
        case (b)
            8'h7E:   r = 8'h30;   // '~'
            8'h21:   r = 8'h31;   // '!'
            8'h40:   r = 8'h32;   // '@'
            8'h23:   r = 8'h33;   // '#'
            8'h24:   r = 8'h34;   // '$'
            8'h29:   r = 8'h35;   // ')'
            8'h5E:   r = 8'h36;   // '^'
            8'h26:   r = 8'h37;   // '&'
            8'h2A:   r = 8'h38;   // '*'
            8'h28:   r = 8'h39;   // '('
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

### src/grld_front.sv
module grld_front #(
    parameter int GROUP_MAX = grld_pkg::GROUP_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  grld_pkg::t_byte    i_byte,
    output logic               o_push,
    output grld_pkg::t_grp_cmd o_cmd,
    input  logic               i_full
);
    import grld_pkg::*;

    logic             r_in_group, n_in_group;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_ovf, n_ovf;
    t_byte [STORE_DEPTH-1:0] r_store;

    logic  accept;
    logic  is_digit;
    logic  is_close;
    logic  store_we;
    t_byte digit_val;

    // Take a word whenever the queue has room
    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign is_digit = (i_byte >= DIGIT_LO) && (i_byte <= DIGIT_HI);
    assign is_close = (i_byte == CLOSE_MARK);
    assign digit_val = i_byte - ASCII_ZERO;

    // Classify the word and build the command for the back
    always_comb begin
        n_in_group = r_in_group;
        n_cnt      = r_cnt;
        n_len      = r_len;
        n_ovf      = r_ovf;
        store_we   = 1'b0;
        o_push     = 1'b0;
        o_cmd.bytes = r_store;
        o_cmd.len   = r_len;
        o_cmd.cnt   = r_cnt;
        o_cmd.ovf   = r_ovf;
        if (accept) begin
            if (!r_in_group) begin
                if (is_digit) begin
                    n_in_group = 1'b1;
                    n_cnt      = digit_val[CNT_W-1:0];
                    n_len      = '0;
                    n_ovf      = 1'b0;
                end else begin
                    // Pass through as a group of one
                    o_push         = 1'b1;
                    o_cmd.bytes[0] = i_byte;
                    o_cmd.len      = LEN_W'(1);
                    o_cmd.cnt      = CNT_W'(1);
                    o_cmd.ovf      = 1'b0;
                end
            end else if (is_close) begin
                // Close: hand over the group unless empty, then clear
                o_push     = (r_len != '0);
                n_in_group = 1'b0;
                n_cnt      = '0;
                n_len      = '0;
                n_ovf      = 1'b0;
            end else if (r_len < LEN_W'(GROUP_MAX)) begin
                store_we = 1'b1;
                n_len    = r_len + LEN_W'(1);
            end else begin
                // Full: drop the byte and flag it
                n_ovf = 1'b1;
            end
        end
    end

    // Hold group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_group <= 1'b0;
            r_cnt      <= '0;
            r_len      <= '0;
            r_ovf      <= 1'b0;
        end else begin
            r_in_group <= n_in_group;
            r_cnt      <= n_cnt;
            r_len      <= n_len;
            r_ovf      <= n_ovf;
        end
    end

    // Collect group bytes
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_len] <= i_byte;
        end
    end

endmodule

### src/grld_queue.sv
module grld_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  grld_pkg::t_grp_cmd i_cmd,
    output logic               o_full,
    input  logic               i_pop,
    output grld_pkg::t_grp_cmd o_head,
    output logic               o_valid
);
    import grld_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_grp_cmd          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_QW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_QW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    // Advance pointers and fill count
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_QW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_QW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Hold queued words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

### src/grld_back.sv
module grld_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  grld_pkg::t_grp_cmd i_cmd,
    output logic               o_pop,
    output logic               o_tvalid,
    input  logic               i_tready,
    output grld_pkg::t_byte    o_tdata,
    output logic               o_tlast,
    output logic               o_tuser
);
    import grld_pkg::*;

    logic             r_tvalid;
    t_byte            r_tdata;
    logic             r_tlast;
    logic             r_tuser;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_rep, n_rep;

    logic load;
    logic step;
    logic last_byte;
    logic last_rep;

    // Load the output register when empty or being drained
    assign load      = !r_tvalid || i_tready;
    assign step      = load && i_valid;
    assign last_byte = (r_idx == i_cmd.len - LEN_W'(1));
    assign last_rep  = (r_rep == i_cmd.cnt - CNT_W'(1));
    assign o_pop     = step && last_byte && last_rep;

    // Walk the group bytes, then the repeats
    always_comb begin
        n_idx = r_idx;
        n_rep = r_rep;
        if (step) begin
            if (last_byte) begin
                n_idx = '0;
                n_rep = last_rep ? '0 : r_rep + CNT_W'(1);
            end else begin
                n_idx = r_idx + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
            r_idx    <= '0;
            r_rep    <= '0;
        end else begin
            r_idx <= n_idx;
            r_rep <= n_rep;
            if (load) begin
                r_tvalid <= i_valid;
            end
        end
    end

    // Register the next result word
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_tdata <= substitute(i_cmd.bytes[r_idx]);
            r_tlast <= last_byte && last_rep;
            r_tuser <= i_cmd.ovf;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;
    assign o_tuser  = r_tuser;

endmodule

### src/group_repeat_run_length_decoder.sv
// Group-repeat run-length decoder.
// Slave stream: one text byte per word on s_axis_tdata. A digit 2 to 9 outside
// a group opens a group; bytes up to the next comma are collected and the group
// is replayed that many times at the comma. Other bytes pass straight through.
// Master stream: one decoded byte per word on m_axis_tdata, with symbol-to-digit
// substitution applied; m_axis_tlast marks the final word caused by one input
// word and m_axis_tuser flags a group that dropped bytes beyond GROUP_MAX.
// With the back idle, a pass-through byte that is taken goes through the queue
// and then the output register before it is offered on the master side. A
// closing comma hands its group to the queue; the single replay walker gives
// length times count words, one per cycle while the receiver takes them, up to
// 63. Opening digits and collected bytes give no output words.
// The front takes one word per cycle while the two-word queue to the back has
// room, so a long replay stalls the input once the queue fills.
// Reset clears the group state, the queue and the output valid; nothing is lost
// when the receiver stalls: the output word holds until taken and the queue
// backs up to s_axis_tready.
module group_repeat_run_length_decoder #(
    parameter int GROUP_MAX = grld_pkg::GROUP_MAX_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  grld_pkg::t_byte s_axis_tdata,   // [7:0] in_byte
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output grld_pkg::t_byte m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast,   // last_of_run
    output logic            m_axis_tuser    // [0] overflow
);
    import grld_pkg::*;

    logic     push;
    logic     full;
    logic     pop;
    logic     head_valid;
    t_grp_cmd cmd_in;
    t_grp_cmd cmd_head;

    grld_front #(
        .GROUP_MAX(GROUP_MAX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .o_push  (push),
        .o_cmd   (cmd_in),
        .i_full  (full)
    );

    grld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (cmd_head),
        .o_valid (head_valid)
    );

    grld_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (head_valid),
        .i_cmd    (cmd_head),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );

endmodule
